@@ rtl/dtpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dtpc_pkg: shared types and constants
// Provides item structs, op codes, register map and sizing constants for the
// tile plane compositor.
// ----------------------------------------------------------------------------
`default_nettype none
package dtpc_pkg;

    localparam int VIDEO_BYTES_DEF   = 65536;
    localparam int VSCROLL_BYTES_DEF = 80;

    // Video memory reads of one render item, in issue order
    localparam int NSTEPS = 10;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_HS_LAST = 4'd3;
    localparam logic [STEP_W-1:0] STEP_NA0     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_NA1     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_NB0     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_NB1     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_PA      = 4'd8;
    localparam logic [STEP_W-1:0] STEP_PB      = 4'd9;

    typedef enum logic [1:0] {
        OP_VWRITE = 2'd0,
        OP_SWRITE = 2'd1,
        OP_RENDER = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Register map (word index)
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_A_BASE  = 3'd0;
    localparam logic [2:0] REG_B_BASE  = 3'd1;
    localparam logic [2:0] REG_HS_BASE = 3'd2;
    localparam logic [2:0] REG_SIZE    = 3'd3;
    localparam logic [2:0] REG_MODES   = 3'd4;
    localparam logic [2:0] REG_ENABLE  = 3'd5;
    localparam logic [2:0] REG_BG      = 3'd6;

    localparam logic [15:0] HSCROLL_BIAS = 16'h0400;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  color_index;
        logic [1:0]  palette_line;
        logic [2:0]  top_layer;
        logic [10:0] pattern_number;
    } t_out_item;

    typedef struct packed {
        logic [15:0] plane_a_base;
        logic [15:0] plane_b_base;
        logic [15:0] hscroll_base;
        logic [3:0]  plane_size;
        logic [2:0]  scroll_modes;
        logic [3:0]  layer_enable;
        logic [5:0]  background_color;
    } t_cfg;

    typedef struct packed {
        logic              latch;     // take the input item
        logic              vwrite;    // write video byte at held address
        logic              swrite;    // write scroll byte from input item
        logic              load_addr; // register read address of step
        logic              capture;   // store read byte of step
        logic              emit;      // register and strobe the result
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    function automatic logic [1:0] sat_code(input logic [1:0] c);
        return (c == 2'd3) ? 2'd2 : c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/dtpc_ram.sv @@
// ----------------------------------------------------------------------------
// dtpc_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module dtpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/dtpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtpc_ctrl: item sequencer
// Decodes accepted items and steps the datapath through its memory reads.
// ----------------------------------------------------------------------------
`default_nettype none
module dtpc_ctrl import dtpc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_op,
    output logic            o_busy,
    output t_dp_cmd         o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_ADDR  = 6'b000100,
        S_READ  = 6'b001000,
        S_CAP   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = accept;
                if (accept) begin
                    case (t_op'(i_op))
                        OP_VWRITE: n_state = S_WRITE;
                        OP_SWRITE: o_cmd.swrite = 1'b1;
                        OP_RENDER: begin
                            n_state = S_ADDR;
                            n_step  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.vwrite = 1'b1;
                n_state = S_IDLE;
            end
            S_ADDR: begin
                o_cmd.load_addr = 1'b1;
                n_state = S_READ;
            end
            S_READ: n_state = S_CAP;
            S_CAP: begin
                o_cmd.capture = 1'b1;
                if (r_step == STEP_W'(NSTEPS - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_ADDR;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end
endmodule
`default_nettype wire

@@ rtl/dtpc_dp.sv @@
// ----------------------------------------------------------------------------
// dtpc_dp: compositor datapath
// Holds both memories, builds read addresses, captures bytes, composes.
// ----------------------------------------------------------------------------
`default_nettype none
module dtpc_dp import dtpc_pkg::*; #(
    parameter int VIDEO_BYTES   = VIDEO_BYTES_DEF,
    parameter int VSCROLL_BYTES = VSCROLL_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output logic          o_valid,
    output t_out_item     o_result
);
    localparam int VAW = $clog2(VIDEO_BYTES);
    localparam int SAW = $clog2(VSCROLL_BYTES);
    // floor(2^32/V)+1 gives the exact quotient for any 16-bit address
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / VIDEO_BYTES + 1);
    localparam logic [16:0] VDEPTH = 17'(VIDEO_BYTES);

    t_in_item    r_item;
    logic [15:0] r_vaddr;
    logic [SAW-1:0] r_sidx;
    logic        r_sok;
    logic [7:0]  r_byte [NSTEPS];
    logic [7:0]  r_vs [4];

    logic [48:0] prod;
    logic [4:0]  quot;
    logic [16:0] rem;
    logic [VAW-1:0] vidx;
    logic [7:0]  vdata, sdata;

    // address reduction modulo the video memory depth
    always_comb begin
        prod = 49'(r_vaddr) * 49'(RECIP);
        quot = prod[36:32];
        rem  = 17'(r_vaddr) - 17'(22'(quot) * 22'(VDEPTH));
        vidx = rem[VAW-1:0];
    end

    dtpc_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_vram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.vwrite),
        .i_waddr(vidx),
        .i_wdata(r_item.write_data),
        .i_raddr(vidx),
        .o_rdata(vdata)
    );

    logic s_we;
    assign s_we = i_cmd.swrite && (i_item.address < 16'(VSCROLL_BYTES));

    dtpc_ram #(.WIDTH(8), .DEPTH(VSCROLL_BYTES)) u_sram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(i_item.address[SAW-1:0]),
        .i_wdata(i_item.write_data),
        .i_raddr(r_sidx),
        .o_rdata(sdata)
    );

    // geometry
    logic [1:0]  wcode, hcode;
    logic [9:0]  wmask, hmask;
    logic [15:0] hoff;
    logic [6:0]  voff;
    logic [10:0] s_a, s_b, v_a, v_b;
    logic [9:0]  ax, ay, bx, by;
    logic [15:0] name_a, name_b;
    logic [10:0] pat_a, pat_b;
    logic [2:0]  ix_a, iy_a, ix_b, iy_b;
    logic [15:0] paddr_a, paddr_b;
    logic [15:0] rd_addr;
    logic [6:0]  s_addr;

    function automatic logic [15:0] name_addr(input logic [15:0] base, input logic [9:0] px,
                                              input logic [9:0] py, input logic [1:0] wc);
        logic [15:0] off;
        off = 16'(px[9:3]) + (16'(py[9:3]) << (5 + wc));
        return base + (off << 1);
    endfunction

    always_comb begin
        wcode = sat_code(i_cfg.plane_size[1:0]);
        hcode = sat_code(i_cfg.plane_size[3:2]);
        wmask = 10'((11'd256 << wcode) - 11'd1);
        hmask = 10'((11'd256 << hcode) - 11'd1);
        case (i_cfg.scroll_modes[1:0])
            2'd0:    hoff = i_cfg.hscroll_base;
            2'd1:    hoff = i_cfg.hscroll_base + {6'd0, r_item.pixel_y & 8'hF8, 2'd0};
            default: hoff = i_cfg.hscroll_base + {6'd0, r_item.pixel_y, 2'd0};
        endcase
        voff = i_cfg.scroll_modes[2] ? {r_item.pixel_x[8:4], 2'd0} : 7'd0;
        s_a = {r_byte[0][2:0], r_byte[1]};
        s_b = {r_byte[2][2:0], r_byte[3]};
        v_a = {r_vs[0][2:0], r_vs[1]};
        v_b = {r_vs[2][2:0], r_vs[3]};
        ax = 10'(16'(r_item.pixel_x) + HSCROLL_BIAS - 16'(s_a)) & wmask;
        bx = 10'(16'(r_item.pixel_x) + HSCROLL_BIAS - 16'(s_b)) & wmask;
        ay = 10'(11'(r_item.pixel_y) + v_a) & hmask;
        by = 10'(11'(r_item.pixel_y) + v_b) & hmask;
        name_a = name_addr(i_cfg.plane_a_base, ax, ay, wcode);
        name_b = name_addr(i_cfg.plane_b_base, bx, by, wcode);
        pat_a = {r_byte[4][2:0], r_byte[5]};
        pat_b = {r_byte[6][2:0], r_byte[7]};
        ix_a = r_byte[4][3] ? ~ax[2:0] : ax[2:0];
        iy_a = r_byte[4][4] ? ~ay[2:0] : ay[2:0];
        ix_b = r_byte[6][3] ? ~bx[2:0] : bx[2:0];
        iy_b = r_byte[6][4] ? ~by[2:0] : by[2:0];
        paddr_a = {pat_a, 5'd0} + {11'd0, iy_a, ix_a[2:1]};
        paddr_b = {pat_b, 5'd0} + {11'd0, iy_b, ix_b[2:1]};
        case (i_cmd.step)
            STEP_NA0: rd_addr = name_a;
            STEP_NA1: rd_addr = name_a + 16'd1;
            STEP_NB0: rd_addr = name_b;
            STEP_NB1: rd_addr = name_b + 16'd1;
            STEP_PA:  rd_addr = paddr_a;
            STEP_PB:  rd_addr = paddr_b;
            default:  rd_addr = hoff + 16'(i_cmd.step);
        endcase
        s_addr = voff + 7'(i_cmd.step[1:0]);
    end

    // compose
    logic [3:0] pix_a, pix_b;
    logic [2:0] top;
    t_out_item  res;

    always_comb begin
        pix_a = ix_a[0] ? r_byte[8][3:0] : r_byte[8][7:4];
        pix_b = ix_b[0] ? r_byte[9][3:0] : r_byte[9][7:4];
        top = 3'd0;
        if (i_cfg.layer_enable[0] && !r_byte[6][7] && pix_b != 4'd0) top = 3'd1;
        if (i_cfg.layer_enable[1] && !r_byte[4][7] && pix_a != 4'd0) top = 3'd2;
        if (i_cfg.layer_enable[2] &&  r_byte[6][7] && pix_b != 4'd0) top = 3'd3;
        if (i_cfg.layer_enable[3] &&  r_byte[4][7] && pix_a != 4'd0) top = 3'd4;
        res.top_layer = top;
        case (top)
            3'd0: begin
                res.color_index    = i_cfg.background_color[3:0];
                res.palette_line   = i_cfg.background_color[5:4];
                res.pattern_number = '0;
            end
            3'd2, 3'd4: begin
                res.color_index    = pix_a;
                res.palette_line   = r_byte[4][6:5];
                res.pattern_number = pat_a;
            end
            default: begin
                res.color_index    = pix_b;
                res.palette_line   = r_byte[6][6:5];
                res.pattern_number = pat_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item  <= i_item;
            r_vaddr <= i_item.address;
        end
        if (i_cmd.load_addr) begin
            r_vaddr <= rd_addr;
            r_sidx  <= s_addr[SAW-1:0];
            r_sok   <= (s_addr < 7'(VSCROLL_BYTES));
        end
        if (i_cmd.capture) begin
            r_byte[i_cmd.step] <= vdata;
            if (i_cmd.step <= STEP_HS_LAST) begin
                r_vs[i_cmd.step[1:0]] <= r_sok ? sdata : 8'd0;
            end
        end
        if (i_cmd.emit) begin
            o_result <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end
endmodule
`default_nettype wire

@@ rtl/dual_tile_plane_pixel_compositor_unit.sv @@
// ----------------------------------------------------------------------------
// dual_tile_plane_pixel_compositor_unit: two-plane tile compositor
// Scrolls planes A and B, fetches name entries and pattern pixels from video
// memory and composes the shown pixel by priority over the background.
// ----------------------------------------------------------------------------
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+---------------------------
//  item in   | i_start, i_item, o_busy             | taken when start & !busy
//  result    | o_result_valid, o_result            | one-cycle strobe, no stall
//  config    | psel penable pwrite paddr pwdata ...| APB, pready tied high
//
// A video write goes through the write state, a scroll write is stored as
// the item is accepted, and a render item makes its 10 video memory reads,
// each through address register, RAM read and capture states, then emits.
// The single byte-wide video memory read port forces this order; scroll reads
// ride along on their own memory during the first four reads.
// Reset clears sequencer, config and result strobe; memories and datapath
// registers start unknown. The result strobe cannot be held off by receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module dual_tile_plane_pixel_compositor_unit import dtpc_pkg::*; #(
    parameter int VIDEO_BYTES   = VIDEO_BYTES_DEF,
    parameter int VSCROLL_BYTES = VSCROLL_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_in_item          i_item,
    output logic                   o_busy,
    output logic                   o_result_valid,
    output t_out_item              o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    t_cfg    r_cfg;
    t_dp_cmd cmd;
    logic    cfg_we;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    // register file: write on the access phase, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plane_a_base     <= 16'hC000;
            r_cfg.plane_b_base     <= 16'hE000;
            r_cfg.hscroll_base     <= 16'hFC00;
            r_cfg.plane_size       <= 4'd0;
            r_cfg.scroll_modes     <= 3'd0;
            r_cfg.layer_enable     <= 4'hF;
            r_cfg.background_color <= 6'd0;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_A_BASE:  r_cfg.plane_a_base     <= pwdata[15:0];
                REG_B_BASE:  r_cfg.plane_b_base     <= pwdata[15:0];
                REG_HS_BASE: r_cfg.hscroll_base     <= pwdata[15:0];
                REG_SIZE:    r_cfg.plane_size       <= pwdata[3:0];
                REG_MODES:   r_cfg.scroll_modes     <= pwdata[2:0];
                REG_ENABLE:  r_cfg.layer_enable     <= pwdata[3:0];
                REG_BG:      r_cfg.background_color <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_A_BASE:  prdata = {16'd0, r_cfg.plane_a_base};
            REG_B_BASE:  prdata = {16'd0, r_cfg.plane_b_base};
            REG_HS_BASE: prdata = {16'd0, r_cfg.hscroll_base};
            REG_SIZE:    prdata = {28'd0, r_cfg.plane_size};
            REG_MODES:   prdata = {29'd0, r_cfg.scroll_modes};
            REG_ENABLE:  prdata = {28'd0, r_cfg.layer_enable};
            REG_BG:      prdata = {26'd0, r_cfg.background_color};
            default:     prdata = 32'd0;
        endcase
    end

    dtpc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_op   (i_item.op),
        .o_busy (o_busy),
        .o_cmd  (cmd)
    );

    dtpc_dp #(
        .VIDEO_BYTES  (VIDEO_BYTES),
        .VSCROLL_BYTES(VSCROLL_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (o_result_valid),
        .o_result(o_result)
    );
endmodule
`default_nettype wire
